FILE: src/sss_pkg.sv
// ----------------------------------------------------------------------------
// sss_pkg
// Shared types, state encodings and the Sedgwick gap table of the sort engine.
// ----------------------------------------------------------------------------
package sss_pkg;

    localparam int GAP_COUNT = 12;   // gaps 1 .. 16001 cover n/2 up to 32768
    localparam int GAP_IDX_W = 4;
    localparam int GAP_W     = 17;
    localparam int DATA_W    = 32;

    // request operation codes
    localparam logic OP_LOAD = 1'b0;
    localparam logic OP_READ = 1'b1;

    typedef enum logic [1:0] {
        TOP_IDLE,
        TOP_READ,
        TOP_SORT
    } top_state_t;

    typedef enum logic [2:0] {
        SRT_IDLE,
        SRT_INIT,
        SRT_PASS,
        SRT_WT_T,
        SRT_CMP,
        SRT_WR
    } sort_state_t;

    typedef struct packed {
        logic busy;
        logic done;
    } sss_stat_t;

    // Sedgwick gaps, index 0 upwards
    function automatic logic [GAP_W-1:0] sss_gap(input logic [GAP_IDX_W-1:0] idx);
        case (idx)
            4'd0:    sss_gap = 17'd1;
            4'd1:    sss_gap = 17'd5;
            4'd2:    sss_gap = 17'd19;
            4'd3:    sss_gap = 17'd41;
            4'd4:    sss_gap = 17'd109;
            4'd5:    sss_gap = 17'd209;
            4'd6:    sss_gap = 17'd505;
            4'd7:    sss_gap = 17'd929;
            4'd8:    sss_gap = 17'd2161;
            4'd9:    sss_gap = 17'd3905;
            4'd10:   sss_gap = 17'd8929;
            4'd11:   sss_gap = 17'd16001;
            default: sss_gap = 17'd36289;
        endcase
    endfunction

endpackage

FILE: src/sss_ram.sv
// ----------------------------------------------------------------------------
// sss_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module sss_ram #(
    parameter int WIDTH  = 32,
    parameter int DEPTH  = 1024,
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              aclk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [WIDTH-1:0]  wdata,
    input  logic              re,
    input  logic [ADDR_W-1:0] raddr,
    output logic [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

FILE: src/sss_sorter.sv
// ----------------------------------------------------------------------------
// sss_sorter
// Gapped insertion sequencer: walks the store once per gap, largest first.
// ----------------------------------------------------------------------------
module sss_sorter #(
    parameter int MAX_ELEMENTS = 1024,
    localparam int CNT_W  = $clog2(MAX_ELEMENTS + 1),
    localparam int ADDR_W = (MAX_ELEMENTS > 1) ? $clog2(MAX_ELEMENTS) : 1
) (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      start,
    input  logic [CNT_W-1:0]          n_in,
    output sss_pkg::sss_stat_t        stat,
    output logic                      ram_we,
    output logic [ADDR_W-1:0]         ram_waddr,
    output logic [sss_pkg::DATA_W-1:0] ram_wdata,
    output logic                      ram_re,
    output logic [ADDR_W-1:0]         ram_raddr,
    input  logic [sss_pkg::DATA_W-1:0] ram_rdata
);
    import sss_pkg::*;

    sort_state_t state_reg, state_next;

    logic [CNT_W-1:0]        n_reg;
    logic [GAP_IDX_W-1:0]    k_reg;
    logic [CNT_W-1:0]        gap_reg;
    logic [CNT_W-1:0]        i_reg;
    logic [CNT_W-1:0]        j_reg;
    logic signed [DATA_W-1:0] t_reg;

    logic [GAP_IDX_W-1:0] top_cnt;
    logic [CNT_W-1:0]     gap_sel;
    logic [CNT_W-1:0]     j_dn;
    logic [CNT_W-1:0]     j_dn2;
    logic [CNT_W-1:0]     i_up;
    logic                 j_dn_ok;
    logic                 i_more;
    logic                 cmp_gt;
    logic                 last_pass;

    // number of gaps not above n/2
    always_comb begin
        top_cnt = '0;
        for (int g = 0; g < GAP_COUNT; g++) begin
            if (32'(sss_gap(GAP_IDX_W'(g))) <= 32'(n_reg >> 1)) begin
                top_cnt = top_cnt + 1'b1;
            end
        end
    end

    assign gap_sel   = CNT_W'(sss_gap(k_reg - 1'b1));
    assign j_dn      = j_reg - gap_reg;
    assign j_dn2     = j_dn - gap_reg;
    assign j_dn_ok   = (j_dn >= gap_reg);
    assign i_up      = i_reg + 1'b1;
    assign i_more    = (i_up < n_reg);
    assign cmp_gt    = ($signed(ram_rdata) > t_reg);
    assign last_pass = (k_reg == GAP_IDX_W'(1));

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            SRT_IDLE: begin
                if (start) state_next = SRT_INIT;
            end
            SRT_INIT: begin
                state_next = (n_reg < CNT_W'(2)) ? SRT_IDLE : SRT_PASS;
            end
            SRT_PASS: state_next = SRT_WT_T;
            SRT_WT_T: state_next = SRT_CMP;
            SRT_CMP: begin
                if (cmp_gt) begin
                    state_next = j_dn_ok ? SRT_CMP : SRT_WR;
                end else if (i_more) begin
                    state_next = SRT_WT_T;
                end else begin
                    state_next = last_pass ? SRT_IDLE : SRT_PASS;
                end
            end
            SRT_WR: begin
                if (i_more) begin
                    state_next = SRT_WT_T;
                end else begin
                    state_next = last_pass ? SRT_IDLE : SRT_PASS;
                end
            end
            default: state_next = SRT_IDLE;
        endcase
    end

    // outputs: memory accesses and status
    always_comb begin
        ram_we    = 1'b0;
        ram_waddr = j_reg[ADDR_W-1:0];
        ram_wdata = t_reg;
        ram_re    = 1'b0;
        ram_raddr = i_up[ADDR_W-1:0];
        case (state_reg)
            SRT_PASS: begin
                ram_re    = 1'b1;
                ram_raddr = gap_sel[ADDR_W-1:0];
            end
            SRT_WT_T: begin
                ram_re    = 1'b1;
                ram_raddr = ADDR_W'(i_reg - gap_reg);
            end
            SRT_CMP: begin
                ram_we    = 1'b1;
                ram_wdata = cmp_gt ? ram_rdata : t_reg;
                if (cmp_gt) begin
                    ram_re    = j_dn_ok;
                    ram_raddr = j_dn2[ADDR_W-1:0];
                end else begin
                    ram_re    = i_more;
                end
            end
            SRT_WR: begin
                ram_we = 1'b1;
                ram_re = i_more;
            end
            default: ;
        endcase
        stat.busy = (state_reg != SRT_IDLE);
        stat.done = (state_reg != SRT_IDLE) && (state_next == SRT_IDLE);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= SRT_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // datapath
    always_ff @(posedge aclk) begin
        case (state_reg)
            SRT_IDLE: begin
                if (start) n_reg <= n_in;
            end
            SRT_INIT: k_reg <= top_cnt;
            SRT_PASS: begin
                gap_reg <= gap_sel;
                i_reg   <= gap_sel;
            end
            SRT_WT_T: begin
                t_reg <= $signed(ram_rdata);
                j_reg <= i_reg;
            end
            SRT_CMP: begin
                if (cmp_gt) begin
                    j_reg <= j_dn;
                end else begin
                    i_reg <= i_up;
                    if (!i_more) k_reg <= k_reg - 1'b1;
                end
            end
            SRT_WR: begin
                i_reg <= i_up;
                if (!i_more) k_reg <= k_reg - 1'b1;
            end
            default: ;
        endcase
    end

endmodule

FILE: src/shell_sort_sedgwick_engine.sv
// Results: an empty read result is registered straight from the request; a read
//   with data passes through the RAM read register, then the result register.
// Throughput: one load per cycle while idle and the result register is free or
//   draining; a read with data holds off new requests until its result is registered.
// Sort: after the last load, no requests are taken until all gap passes finish.
// Reset: synchronous, active low; count, read pointer and sorted flag clear.
// ----------------------------------------------------------------------------
// shell_sort_sedgwick_engine
// Loads signed words, Shell sorts them in place (Sedgwick gaps), reads back.
// ----------------------------------------------------------------------------
module shell_sort_sedgwick_engine #(
    parameter int MAX_ELEMENTS = 1024
) (
    input  logic                      aclk,
    input  logic                      aresetn,
    // request channel
    input  logic                      s_valid,
    output logic                      s_ready,
    input  logic                      s_operation,
    input  logic signed [31:0]        s_value_in,
    input  logic                      s_last_in,
    // result channel
    output logic                      m_valid,
    input  logic                      m_ready,
    output logic signed [31:0]        m_value_out,
    output logic                      m_last_out,
    output logic                      m_empty_res
);
    import sss_pkg::*;

    localparam int CNT_W  = $clog2(MAX_ELEMENTS + 1);
    localparam int ADDR_W = (MAX_ELEMENTS > 1) ? $clog2(MAX_ELEMENTS) : 1;

    top_state_t state_reg, state_next;

    logic [CNT_W-1:0]  count_reg;
    logic [CNT_W-1:0]  rptr_reg;
    logic              sorted_reg;
    logic              last_pend_reg;

    logic              m_valid_reg;
    logic [DATA_W-1:0] m_value_reg;
    logic              m_last_reg;
    logic              m_empty_reg;

    // request decode
    logic              req_acc;
    logic              load_acc;
    logic              read_acc;
    logic [CNT_W-1:0]  count_eff;
    logic              room;
    logic [CNT_W-1:0]  count_new;
    logic              has_data;
    logic              sort_start;

    // RAM ports
    logic              ram_we;
    logic [ADDR_W-1:0] ram_waddr;
    logic [DATA_W-1:0] ram_wdata;
    logic              ram_re;
    logic [ADDR_W-1:0] ram_raddr;
    logic [DATA_W-1:0] ram_rdata;

    // sorter ports
    sss_stat_t         srt_stat;
    logic              srt_we;
    logic [ADDR_W-1:0] srt_waddr;
    logic [DATA_W-1:0] srt_wdata;
    logic              srt_re;
    logic [ADDR_W-1:0] srt_raddr;

    // a new request only when idle and the result register is free or draining
    assign s_ready  = (state_reg == TOP_IDLE) && (!m_valid_reg || m_ready);
    assign req_acc  = s_valid && s_ready;
    assign load_acc = req_acc && (s_operation == OP_LOAD);
    assign read_acc = req_acc && (s_operation == OP_READ);

    // a load after a sort starts a fresh data set
    assign count_eff  = sorted_reg ? '0 : count_reg;
    assign room       = (count_eff < CNT_W'(MAX_ELEMENTS));
    assign count_new  = count_eff + CNT_W'(room);
    assign sort_start = load_acc && s_last_in;
    assign has_data   = sorted_reg && (rptr_reg < count_reg);

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            TOP_IDLE: begin
                if (sort_start) begin
                    state_next = TOP_SORT;
                end else if (read_acc && has_data) begin
                    state_next = TOP_READ;
                end
            end
            TOP_READ: state_next = TOP_IDLE;
            TOP_SORT: begin
                if (srt_stat.done) state_next = TOP_IDLE;
            end
            default: state_next = TOP_IDLE;
        endcase
    end

    // RAM port ownership: the sorter while sorting, the request side otherwise
    always_comb begin
        ram_we    = 1'b0;
        ram_waddr = count_eff[ADDR_W-1:0];
        ram_wdata = s_value_in;
        ram_re    = 1'b0;
        ram_raddr = rptr_reg[ADDR_W-1:0];
        case (state_reg)
            TOP_SORT: begin
                ram_we    = srt_we;
                ram_waddr = srt_waddr;
                ram_wdata = srt_wdata;
                ram_re    = srt_re;
                ram_raddr = srt_raddr;
            end
            TOP_IDLE: begin
                ram_we = load_acc && room;
                ram_re = read_acc && has_data;
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= TOP_IDLE;
            count_reg   <= '0;
            rptr_reg    <= '0;
            sorted_reg  <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            // a new result wins over the drain of the old one
            if ((read_acc && !has_data) || (state_reg == TOP_READ)) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
            if (load_acc) begin
                count_reg <= count_new;
                rptr_reg  <= '0;
                // the sorted flag is raised at sort start; reads wait till done
                sorted_reg <= s_last_in;
            end
            if (read_acc && has_data) begin
                rptr_reg <= rptr_reg + 1'b1;
            end
        end
    end

    // result payload
    always_ff @(posedge aclk) begin
        if (read_acc) begin
            last_pend_reg <= ((rptr_reg + 1'b1) == count_reg);
            if (!has_data) begin
                m_value_reg <= '0;
                m_last_reg  <= 1'b0;
                m_empty_reg <= 1'b1;
            end
        end
        if (state_reg == TOP_READ) begin
            m_value_reg <= ram_rdata;
            m_last_reg  <= last_pend_reg;
            m_empty_reg <= 1'b0;
        end
    end

    assign m_valid     = m_valid_reg;
    assign m_value_out = $signed(m_value_reg);
    assign m_last_out  = m_last_reg;
    assign m_empty_res = m_empty_reg;

    sss_ram #(
        .WIDTH (DATA_W),
        .DEPTH (MAX_ELEMENTS)
    ) u_store (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    sss_sorter #(
        .MAX_ELEMENTS (MAX_ELEMENTS)
    ) u_sorter (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .start     (sort_start),
        .n_in      (count_new),
        .stat      (srt_stat),
        .ram_we    (srt_we),
        .ram_waddr (srt_waddr),
        .ram_wdata (srt_wdata),
        .ram_re    (srt_re),
        .ram_raddr (srt_raddr),
        .ram_rdata (ram_rdata)
    );

endmodule

FILE: tb/sort_result_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// sort_result_checker
// Watches both channels of the sort engine, keeps its own copy of the loaded
// set, predicts every read result and compares it field by field.
// ----------------------------------------------------------------------------
module sort_result_checker #(
    parameter int   MAX_ELEMENTS = 1024
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    input  logic                          s_ready,
    input  logic                          s_operation,
    input  logic signed [sss_pkg::DATA_W-1:0] s_value_in,
    input  logic                          s_last_in,
    input  logic                          m_valid,
    input  logic                          m_ready,
    input  logic signed [sss_pkg::DATA_W-1:0] m_value_out,
    input  logic                          m_last_out,
    input  logic                          m_empty_res,
    output int                            pending_reads,
    output int                            mismatches
);
    import sss_pkg::*;

    localparam int DW    = sss_pkg::DATA_W;
    localparam int CNT_W = $clog2(MAX_ELEMENTS + 1);

    typedef struct packed {
        logic signed [DW-1:0] value;
        logic                 last;
        logic                 empty;
    } read_result_t;

    read_result_t         read_results_q [$];
    logic signed [DW-1:0] held_set [MAX_ELEMENTS];
    logic [CNT_W-1:0]     held_count;
    logic [CNT_W-1:0]     next_read;
    logic                 set_sorted;

    function automatic longint sedgwick_gap_at(input int idx);
        longint j;
        if (idx % 2 == 0) begin
            j = idx / 2;
            return 9 * ((longint'(1) << (2 * j)) - (longint'(1) << j)) + 1;
        end
        return 8 * (longint'(1) << idx) - 6 * (longint'(1) << ((idx + 1) / 2)) + 1;
    endfunction

    // in-place Shell sort of the held set, largest usable gap first
    task automatic shell_sort_held();
        int n;
        int top;
        int k;
        int gap;
        int i;
        int j;
        logic signed [DW-1:0] t;
        n = held_count;
        if (n < 2)
            return;
        top = 0;
        while (top < 40 && sedgwick_gap_at(top) <= n / 2)
            top++;
        if (top == 0)
            top = 1;
        for (k = top; k > 0; k--) begin
            gap = int'(sedgwick_gap_at(k - 1));
            for (i = gap; i < n; i++) begin
                t = held_set[i];
                j = i;
                while (j >= gap && held_set[j - gap] > t) begin
                    held_set[j] = held_set[j - gap];
                    j -= gap;
                end
                held_set[j] = t;
            end
        end
    endtask

    task automatic report_mismatch(input string what, input longint got, input longint want);
        $display("%0t ns: mismatch on %s: got %0d, expected %0d", $time, what, got, want);
        mismatches++;
    endtask

    task automatic track_request(input logic op, input logic signed [DW-1:0] val,
                                 input logic lst);
        read_result_t r;
        if (op == OP_LOAD) begin
            // a load after a finished sort opens a fresh set
            if (set_sorted) begin
                held_count = '0;
                next_read  = '0;
                set_sorted = 1'b0;
            end
            // beyond capacity the value is dropped, the last mark still counts
            if (held_count < MAX_ELEMENTS) begin
                held_set[held_count] = val;
                held_count++;
            end
            if (lst) begin
                shell_sort_held();
                next_read  = '0;
                set_sorted = 1'b1;
            end
        end else begin
            if (set_sorted && next_read < held_count) begin
                r.value = held_set[next_read];
                r.last  = (next_read + 1 == held_count);
                r.empty = 1'b0;
                next_read++;
            end else begin
                r       = '0;
                r.empty = 1'b1;
            end
            read_results_q = {read_results_q, r};
        end
    endtask

    task automatic check_result();
        read_result_t want;
        if (read_results_q.size() == 0) begin
            report_mismatch("result with no read pending", m_value_out, 0);
            return;
        end
        want = read_results_q.pop_front();
        if (m_value_out !== want.value)
            report_mismatch("value_out", m_value_out, want.value);
        if (m_last_out !== want.last)
            report_mismatch("last_out", m_last_out, want.last);
        if (m_empty_res !== want.empty)
            report_mismatch("empty_res", m_empty_res, want.empty);
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            held_count = '0;
            next_read  = '0;
            set_sorted = 1'b0;
            read_results_q.delete();
        end else begin
            if (s_valid && s_ready)
                track_request(s_operation, s_value_in, s_last_in);
            if (m_valid && m_ready)
                check_result();
        end
        pending_reads = read_results_q.size();
    end

endmodule

FILE: tb/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Drives load and read requests into the Shell sort engine: directed corner
// cases, then random data sets of varied shape and one back-pressure burst.
// The checker beside the engine predicts the results.
// ----------------------------------------------------------------------------
module tb_top;
    import sss_pkg::*;

    localparam int   MAX_ELEMENTS    = 1024;
    localparam int   RANDOM_REQUESTS = 560;
    localparam int   HOLD_CYCLES     = 400;   // receiver hold-off for the pressure burst
    localparam int   DRAIN_CYCLES    = 20;    // settle time after the last read result
    localparam int   IDLE_PERCENT    = 29;

    // value shapes for a data set
    localparam int STYLE_RANDOM  = 0;
    localparam int STYLE_NARROW  = 1;   // many duplicates
    localparam int STYLE_EXTREME = 2;
    localparam int STYLE_ASCEND  = 3;
    localparam int STYLE_DESCEND = 4;

    logic        aclk;
    logic        aresetn;
    logic        s_valid;
    logic        s_ready;
    logic        s_operation;
    logic [31:0] s_value_in;
    logic        s_last_in;
    logic        m_valid;
    logic        m_ready;
    logic [31:0] m_value_out;
    logic        m_last_out;
    logic        m_empty_res;

    int pending_reads;
    int mismatches;
    int requests_sent;
    int hold_reqs;      // bumped by the stimulus, served by the receiver
    bit no_idle;        // suppresses random idling on both sides

    shell_sort_sedgwick_engine #(
        .MAX_ELEMENTS(MAX_ELEMENTS)
    ) u_dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_operation (s_operation),
        .s_value_in  (s_value_in),
        .s_last_in   (s_last_in),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_value_out (m_value_out),
        .m_last_out  (m_last_out),
        .m_empty_res (m_empty_res)
    );

    sort_result_checker #(
        .MAX_ELEMENTS (MAX_ELEMENTS)
    ) u_checker (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_operation   (s_operation),
        .s_value_in    (s_value_in),
        .s_last_in     (s_last_in),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_value_out   (m_value_out),
        .m_last_out    (m_last_out),
        .m_empty_res   (m_empty_res),
        .pending_reads (pending_reads),
        .mismatches    (mismatches)
    );

    initial aclk = 1'b0;
    always #5 aclk = ~aclk;

    // Hard stop: the slowest legal run is well under a tenth of this.
    initial begin
        #15_000_000;
        $display("shell_sort_sedgwick_engine test failed");
        $finish;
    end

    // Receiver: random ready, plus a long hold-off whenever the stimulus
    // asks for one. Changes only on the falling edge.
    initial begin
        int hold_seen;
        hold_seen = 0;
        m_ready   = 1'b0;
        forever begin
            @(negedge aclk);
            if (hold_reqs != hold_seen) begin
                hold_seen = hold_reqs;
                for (int k = 0; k < HOLD_CYCLES; k++) begin
                    m_ready <= 1'b0;
                    @(negedge aclk);
                end
            end
            m_ready <= no_idle || ($urandom_range(0, 99) >= IDLE_PERCENT);
        end
    end

    // One request: optional idle gap, then hold valid until accepted.
    // Returns just after the accepting rising edge.
    task automatic send_request(input logic op, input logic [31:0] val, input logic lst);
        @(negedge aclk);
        while (!no_idle && $urandom_range(0, 99) < IDLE_PERCENT) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid     <= 1'b1;
        s_operation <= op;
        s_value_in  <= val;
        s_last_in   <= lst;
        do
            @(posedge aclk);
        while (!s_ready);
        requests_sent++;
    endtask

    // read with junk in the ignored fields
    task automatic send_read();
        send_request(OP_READ, $urandom(), 1'($urandom_range(0, 1)));
    endtask

    function automatic logic [31:0] pick_value(input int style, input int idx);
        logic [31:0] v;
        case (style)
            STYLE_NARROW:  v = $urandom_range(0, 7) - 4;
            STYLE_EXTREME: begin
                case ($urandom_range(0, 5))
                    0:       v = 32'h8000_0000;
                    1:       v = 32'h7fff_ffff;
                    2:       v = 32'h0000_0000;
                    3:       v = 32'hffff_ffff;
                    4:       v = 32'h8000_0001;
                    default: v = 32'h7fff_fffe;
                endcase
            end
            STYLE_ASCEND:  v = 32'hffff_ff00 + idx * 3;
            STYLE_DESCEND: v = 32'h0000_1000 - idx * 5;
            default:       v = $urandom();
        endcase
        return v;
    endfunction

    // Load n values, last mark on the final one; noise inserts stray reads
    // that land before the sort and so come back empty (or drain an old set).
    task automatic load_set(input int n, input int style, input bit noise);
        for (int i = 0; i < n; i++) begin
            if (noise && $urandom_range(0, 99) < 5)
                send_read();
            send_request(OP_LOAD, pick_value(style, i), i == n - 1);
        end
    endtask

    task automatic read_back(input int n);
        for (int i = 0; i < n; i++)
            send_read();
    endtask

    initial begin
        int n;
        int pick;
        int set_idx;

        aresetn       = 1'b0;
        s_valid       = 1'b0;
        s_operation   = OP_LOAD;
        s_value_in    = '0;
        s_last_in     = 1'b0;
        requests_sent = 0;
        hold_reqs     = 0;
        no_idle       = 1'b0;

        repeat (4) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // --- directed part ---
        // read before any sort
        send_request(OP_READ, 32'hdead_beef, 1'b1);
        // single-element set at the most negative value
        send_request(OP_LOAD, 32'h8000_0000, 1'b1);
        send_read();
        send_read();                                   // drained: empty
        // extremes, duplicates, sign boundary
        send_request(OP_LOAD, 32'h7fff_ffff, 1'b0);
        send_request(OP_LOAD, 32'h8000_0000, 1'b0);
        send_request(OP_LOAD, 32'h0000_0000, 1'b0);
        send_request(OP_LOAD, 32'hffff_ffff, 1'b0);
        send_request(OP_LOAD, 32'h0000_0001, 1'b0);
        send_request(OP_LOAD, 32'h7fff_ffff, 1'b0);
        send_request(OP_LOAD, 32'h8000_0001, 1'b1);
        read_back(3);
        // load after a partly read sort opens a new set; read mid-load is empty
        send_request(OP_LOAD, 32'h0000_0005, 1'b0);
        send_read();
        send_request(OP_LOAD, 32'hffff_fffb, 1'b1);
        read_back(3);
        // two elements: only gap 1 applies
        send_request(OP_LOAD, 32'h0000_0002, 1'b0);
        send_request(OP_LOAD, 32'h0000_0001, 1'b1);
        read_back(3);

        // --- random data sets ---
        requests_sent = 0;
        set_idx       = 0;
        while (requests_sent < RANDOM_REQUESTS) begin
            no_idle = (set_idx >= 6 && set_idx < 12);
            pick    = $urandom_range(0, 99);
            if (pick < 8) begin
                // stray request of any kind
                send_request(1'($urandom_range(0, 1)), $urandom(),
                             1'($urandom_range(0, 1)));
            end else begin
                n = ($urandom_range(0, 9) == 0) ? $urandom_range(60, 200)
                                                : $urandom_range(1, 40);
                load_set(n, $urandom_range(STYLE_RANDOM, STYLE_DESCEND), 1'b1);
                if (pick < 20)
                    read_back(n / 2);                  // abandoned part way
                else
                    read_back(n + $urandom_range(0, 2));
            end
            set_idx++;
        end

        // --- back-pressure: receiver holds off while reads keep coming ---
        no_idle = 1'b1;
        load_set(24, STYLE_RANDOM, 1'b0);
        send_read();                                   // accepted once sort is done
        hold_reqs++;
        read_back(40);
        no_idle = 1'b0;

        @(negedge aclk);
        s_valid <= 1'b0;

        wait (pending_reads == 0);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (mismatches == 0 && pending_reads == 0)
            $display("shell_sort_sedgwick_engine test passed");
        else
            $display("shell_sort_sedgwick_engine test failed");
        $finish;
    end

endmodule
